@@ hdl/sega_pkg.sv @@
// Shared types and constants for the exposure and gain metadata block.
`default_nettype none
package sega_pkg;

    localparam int LinesW   = 20;
    localparam int CodeW    = 16;
    localparam int CfgW     = 32;
    localparam int DenW     = 36;
    localparam int NumW     = 72;
    localparam int QuoW     = 32;
    localparam int GNumW    = 21;
    localparam int GDivW    = 11;
    localparam int GainW    = 20;
    localparam int IsoW     = 16;
    localparam int IsoXW    = 26;
    localparam int IsoRecW  = 27;
    localparam int IsoShift = 36;
    localparam int Stages   = 32;
    localparam int QDepth   = 4;
    localparam int QPtrW    = 2;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_SETTING  = 2'd1;
    localparam status_t ST_EXPOSURE = 2'd2;
    localparam status_t ST_GAIN     = 2'd3;

    typedef logic [1:0] reg_idx_t;
    localparam reg_idx_t REG_ACTIVE_WIDTH = 2'd0;
    localparam reg_idx_t REG_HBLANK       = 2'd1;
    localparam reg_idx_t REG_PIXEL_RATE   = 2'd2;

    localparam logic [CfgW-1:0]    RST_ACTIVE_WIDTH = 32'd4000;
    localparam logic [CfgW-1:0]    RST_HBLANK       = 32'd4976;
    localparam logic [CfgW-1:0]    RST_PIXEL_RATE   = 32'd678400000;
    localparam logic [19:0]        US_PER_SECOND    = 20'd1000000;
    localparam logic [CodeW-1:0]   ANALOG_UNITY     = 16'd1024;
    localparam logic [CodeW-1:0]   ANALOG_MIN       = 16'd112;
    localparam logic [CodeW-1:0]   ANALOG_MAX       = 16'd1008;
    localparam logic [CodeW-1:0]   DIGITAL_MIN      = 16'd1264;
    localparam logic [CodeW-1:0]   DIGITAL_MAX      = 16'd5103;
    localparam logic [7:0]         DIGITAL_STEP     = 8'd250;
    localparam logic [GNumW-1:0]   GAIN_NUM_BASE    = 21'd2048000;
    localparam logic [IsoXW-1:0]   ISO_BIAS         = 26'd500;
    localparam logic [IsoRecW-1:0] ISO_RECIP        = 27'd68719477;

    typedef struct packed {
        status_t            st;
        logic               gain_bad;
        logic               analog;
        logic [GNumW-1:0]   gnum;
        logic [GDivW-1:0]   gdiv;
        logic [GainW-1:0]   gdig;
        logic [NumW-1:0]    num;
    } item_t;

    typedef struct packed {
        status_t            st;
        logic               gain_bad;
        logic               analog;
        logic               ovf;
        logic [DenW-1:0]    rem;
        logic [QuoW-1:0]    nlo;
        logic [QuoW-1:0]    q;
        logic [GDivW-1:0]   grem;
        logic [GNumW-1:0]   gnum;
        logic [GDivW-1:0]   gdiv;
        logic [GNumW-1:0]   gq;
        logic [GainW-1:0]   gdig;
    } dstage_t;

endpackage
`default_nettype wire

@@ hdl/sensor_exposure_gain_to_metadata_core.sv @@
// Top level of the exposure and gain to frame metadata converter.
// Input stream: each beat carries exposure_lines (sixteenths of a line) and a
// sensor gain code. Output stream: one beat per input beat with status,
// exposure in microseconds, gain times 1000 and ISO, in input order.
// Three settings (active width, horizontal blanking, pixel rate) are written
// through cfg_we, cfg_addr and cfg_wdata; they must only change while no beat
// is in flight. Writes to an unknown index are ignored.
// Throughput is one beat per cycle while the receiver does not stall. An
// accepted beat passes through two front end stages, the four-entry queue,
// 33 divider stages (a loading stage and 32 restoring steps, each giving one
// exposure quotient bit and, while gain numerator bits remain, one gain
// quotient bit), then rounding, ISO scaling and the output register.
// Reset clears all valid flags and the queue and loads the default settings.
// When the receiver stalls, the output register holds its beat and the back
// end stops; the queue then absorbs up to four beats before the front end, and
// finally s_axis_tready, stall in turn.
`default_nettype none
module sensor_exposure_gain_to_metadata_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic [1:0]    cfg_addr,
    input  wire logic [31:0]   cfg_wdata,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [39:0]   s_axis_tdata,   // exposure_lines[19:0], gain_word[35:20]
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    output logic [71:0]        m_axis_tdata    // status[1:0], exp_time_us[33:2],
                                               // gain_milli[53:34], iso_value[69:54]
);

    logic [sega_pkg::CfgW-1:0]   act_pixels_reg;
    logic [sega_pkg::CfgW-1:0]   hblank_reg;
    logic [sega_pkg::CfgW-1:0]   pix_rate_reg;
    logic                        fq_valid;
    logic                        fq_ready;
    sega_pkg::item_t             fq_item;
    logic                        qb_valid;
    logic                        qb_ready;
    sega_pkg::item_t             qb_item;
    sega_pkg::status_t           status;
    logic [sega_pkg::QuoW-1:0]   exp_time_us;
    logic [sega_pkg::GainW-1:0]  gain_milli;
    logic [sega_pkg::IsoW-1:0]   iso_value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_pixels_reg <= sega_pkg::RST_ACTIVE_WIDTH;
            hblank_reg     <= sega_pkg::RST_HBLANK;
            pix_rate_reg   <= sega_pkg::RST_PIXEL_RATE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                sega_pkg::REG_ACTIVE_WIDTH: act_pixels_reg <= cfg_wdata;
                sega_pkg::REG_HBLANK:       hblank_reg     <= cfg_wdata;
                sega_pkg::REG_PIXEL_RATE:   pix_rate_reg   <= cfg_wdata;
                default:                    ;
            endcase
        end
    end

    sega_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .act_pixels     (act_pixels_reg),
        .blank_pixels   (hblank_reg),
        .pix_rate       (pix_rate_reg),
        .in_valid       (s_axis_tvalid),
        .in_ready       (s_axis_tready),
        .exposure_lines (s_axis_tdata[19:0]),
        .gain_word      (s_axis_tdata[35:20]),
        .out_valid      (fq_valid),
        .out_ready      (fq_ready),
        .out_item       (fq_item)
    );

    sega_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_item   (fq_item),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_item  (qb_item)
    );

    sega_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .pix_rate    (pix_rate_reg),
        .in_valid    (qb_valid),
        .in_ready    (qb_ready),
        .in_item     (qb_item),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .status      (status),
        .exp_time_us (exp_time_us),
        .gain_milli  (gain_milli),
        .iso_value   (iso_value)
    );

    assign m_axis_tdata = {2'b00, iso_value, gain_milli, exp_time_us, status};

endmodule
`default_nettype wire

@@ hdl/sega_front.sv @@
// Front end: accepts beats, checks settings, exposure and gain code, forms the exposure numerator.
`default_nettype none
module sega_front (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [sega_pkg::CfgW-1:0]      act_pixels,
    input  wire logic [sega_pkg::CfgW-1:0]      blank_pixels,
    input  wire logic [sega_pkg::CfgW-1:0]      pix_rate,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [sega_pkg::LinesW-1:0]    exposure_lines,
    input  wire logic [sega_pkg::CodeW-1:0]     gain_word,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output sega_pkg::item_t                     out_item
);

    logic                          f0_v_reg;
    logic [sega_pkg::LinesW-1:0]   f0_lines_reg;
    logic [sega_pkg::CodeW-1:0]    f0_code_reg;
    logic [sega_pkg::CfgW-1:0]     f0_len_reg;
    sega_pkg::status_t             f0_st_reg;
    logic                          f1_v_reg;
    logic [51:0]                   f1_a_reg;
    sega_pkg::item_t               f1_item_reg;
    sega_pkg::item_t               f1_item_next;
    logic [sega_pkg::CfgW:0]       len;
    sega_pkg::status_t             st_next;
    logic                          f1_move;
    logic                          f0_adv;
    logic [sega_pkg::CodeW-1:0]    d_full;
    logic [sega_pkg::CodeW-1:0]    dig_off;

    assign f1_move  = f1_v_reg && out_ready;
    assign f0_adv   = !f1_v_reg || f1_move;
    assign in_ready = !f0_v_reg || f0_adv;
    assign len      = {1'b0, act_pixels} + {1'b0, blank_pixels};

    always_comb
    begin
        if (act_pixels == '0 || pix_rate == '0 || len[sega_pkg::CfgW])
            st_next = sega_pkg::ST_SETTING;
        else if (exposure_lines == '0)
            st_next = sega_pkg::ST_EXPOSURE;
        else
            st_next = sega_pkg::ST_OK;
    end

    always_comb
    begin
        d_full  = sega_pkg::ANALOG_UNITY - f0_code_reg;
        dig_off = f0_code_reg - sega_pkg::ANALOG_MAX;
        f1_item_next.st       = f0_st_reg;
        f1_item_next.analog   = f0_code_reg >= sega_pkg::ANALOG_MIN
                                && f0_code_reg <= sega_pkg::ANALOG_MAX;
        f1_item_next.gain_bad = !f1_item_next.analog
                                && !(f0_code_reg >= sega_pkg::DIGITAL_MIN
                                     && f0_code_reg <= sega_pkg::DIGITAL_MAX);
        f1_item_next.gdiv     = {d_full[sega_pkg::GDivW-2:0], 1'b0};
        f1_item_next.gnum     = sega_pkg::GAIN_NUM_BASE
                                + {{(sega_pkg::GNumW-sega_pkg::GDivW+1){1'b0}},
                                   d_full[sega_pkg::GDivW-2:0]};
        f1_item_next.gdig     = {8'b0, dig_off[11:0]} * {12'b0, sega_pkg::DIGITAL_STEP};
        f1_item_next.num      = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f0_v_reg <= 1'b0;
            f1_v_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                f0_v_reg <= in_valid;
            if (f0_adv)
                f1_v_reg <= f0_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            f0_lines_reg <= exposure_lines;
            f0_code_reg  <= gain_word;
            f0_len_reg   <= len[sega_pkg::CfgW-1:0];
            f0_st_reg    <= st_next;
        end
        if (f0_adv)
        begin
            f1_a_reg    <= f0_lines_reg * f0_len_reg;
            f1_item_reg <= f1_item_next;
        end
    end

    always_comb
    begin
        out_item     = f1_item_reg;
        out_item.num = f1_a_reg * sega_pkg::US_PER_SECOND;
    end

    assign out_valid = f1_v_reg;

endmodule
`default_nettype wire

@@ hdl/sega_queue.sv @@
// Short queue between the front end and the divider pipeline.
`default_nettype none
module sega_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  sega_pkg::item_t       in_item,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output sega_pkg::item_t       out_item
);

    sega_pkg::item_t               mem_reg [sega_pkg::QDepth];
    logic [sega_pkg::QPtrW-1:0]    wr_ptr_reg;
    logic [sega_pkg::QPtrW-1:0]    rd_ptr_reg;
    logic [sega_pkg::QPtrW:0]      cnt_reg;
    logic                          push;
    logic                          pop;

    assign in_ready  = cnt_reg != (sega_pkg::QPtrW+1)'(sega_pkg::QDepth);
    assign out_valid = cnt_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_item  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= in_item;
    end

endmodule
`default_nettype wire

@@ hdl/sega_back.sv @@
// Back end: pipelined restoring dividers, rounding, ISO scaling and the output register.
`default_nettype none
module sega_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [sega_pkg::CfgW-1:0]     pix_rate,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  sega_pkg::item_t                    in_item,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output sega_pkg::status_t                  status,
    output logic [sega_pkg::QuoW-1:0]          exp_time_us,
    output logic [sega_pkg::GainW-1:0]         gain_milli,
    output logic [sega_pkg::IsoW-1:0]          iso_value
);

    localparam int Last = sega_pkg::Stages;

    sega_pkg::dstage_t              s_reg  [Last+1];
    sega_pkg::dstage_t              s_next [Last+1];
    logic [Last:0]                  v_reg;
    logic [sega_pkg::DenW-1:0]      den;
    logic                           en;
    logic [sega_pkg::DenW:0]        t;
    logic [sega_pkg::GDivW:0]       gt;
    logic                           ge;
    logic                           gge;

    logic                           e_v_reg;
    sega_pkg::status_t              e_st_reg;
    logic [sega_pkg::QuoW-1:0]      e_exp_reg;
    logic [sega_pkg::GainW-1:0]     e_gain_reg;
    logic [sega_pkg::IsoXW-1:0]     e_x_reg;
    logic                           p_v_reg;
    sega_pkg::status_t              p_st_reg;
    logic [sega_pkg::QuoW-1:0]      p_exp_reg;
    logic [sega_pkg::GainW-1:0]     p_gain_reg;
    logic [sega_pkg::IsoXW+sega_pkg::IsoRecW-1:0] p_prod_reg;
    logic                           o_v_reg;
    sega_pkg::status_t              o_st_reg;
    logic [sega_pkg::QuoW-1:0]      o_exp_reg;
    logic [sega_pkg::GainW-1:0]     o_gain_reg;
    logic [sega_pkg::IsoW-1:0]      o_iso_reg;

    logic                           fail_e;
    logic                           rnd;
    logic [sega_pkg::QuoW:0]        qr;
    sega_pkg::status_t              st_e;
    logic [sega_pkg::GainW-1:0]     gain_e;

    assign den      = {pix_rate, 4'b0000};
    assign en       = !o_v_reg || out_ready;
    assign in_ready = en;

    always_comb
    begin
        t   = '0;
        gt  = '0;
        ge  = 1'b0;
        gge = 1'b0;
        s_next[0].st       = in_item.st;
        s_next[0].gain_bad = in_item.gain_bad;
        s_next[0].analog   = in_item.analog;
        s_next[0].ovf      = in_item.num[sega_pkg::NumW-1:sega_pkg::QuoW]
                             >= {4'b0000, den};
        s_next[0].rem      = in_item.num[sega_pkg::QuoW+sega_pkg::DenW-1:sega_pkg::QuoW];
        s_next[0].nlo      = in_item.num[sega_pkg::QuoW-1:0];
        s_next[0].q        = '0;
        s_next[0].grem     = '0;
        s_next[0].gnum     = in_item.gnum;
        s_next[0].gdiv     = in_item.gdiv;
        s_next[0].gq       = '0;
        s_next[0].gdig     = in_item.gdig;
        for (int k = 1; k <= Last; k++)
        begin
            s_next[k] = s_reg[k-1];
            t  = {s_reg[k-1].rem, s_reg[k-1].nlo[sega_pkg::QuoW-1]};
            ge = t >= {1'b0, den};
            s_next[k].rem = ge ? sega_pkg::DenW'(t - {1'b0, den}) : t[sega_pkg::DenW-1:0];
            s_next[k].nlo = {s_reg[k-1].nlo[sega_pkg::QuoW-2:0], 1'b0};
            s_next[k].q   = {s_reg[k-1].q[sega_pkg::QuoW-2:0], ge};
            if (k <= sega_pkg::GNumW)
            begin
                gt  = {s_reg[k-1].grem, s_reg[k-1].gnum[sega_pkg::GNumW-1]};
                gge = gt >= {1'b0, s_reg[k-1].gdiv};
                s_next[k].grem = gge ? sega_pkg::GDivW'(gt - {1'b0, s_reg[k-1].gdiv})
                                     : gt[sega_pkg::GDivW-1:0];
                s_next[k].gnum = {s_reg[k-1].gnum[sega_pkg::GNumW-2:0], 1'b0};
                s_next[k].gq   = {s_reg[k-1].gq[sega_pkg::GNumW-2:0], gge};
            end
        end
    end

    always_comb
    begin
        rnd    = {s_reg[Last].rem, 1'b0} >= {1'b0, den};
        qr     = {1'b0, s_reg[Last].q} + {{sega_pkg::QuoW{1'b0}}, rnd};
        fail_e = s_reg[Last].ovf
                 || (s_reg[Last].q == '1 && s_reg[Last].rem != '0)
                 || qr == '0 || qr[sega_pkg::QuoW];
        if (s_reg[Last].st != sega_pkg::ST_OK)
            st_e = s_reg[Last].st;
        else if (fail_e)
            st_e = sega_pkg::ST_EXPOSURE;
        else if (s_reg[Last].gain_bad)
            st_e = sega_pkg::ST_GAIN;
        else
            st_e = sega_pkg::ST_OK;
        gain_e = s_reg[Last].analog ? s_reg[Last].gq[sega_pkg::GainW-1:0] : s_reg[Last].gdig;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg   <= '0;
            e_v_reg <= 1'b0;
            p_v_reg <= 1'b0;
            o_v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg   <= {v_reg[Last-1:0], in_valid};
            e_v_reg <= v_reg[Last];
            p_v_reg <= e_v_reg;
            o_v_reg <= p_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k <= Last; k++)
                s_reg[k] <= s_next[k];
            e_st_reg   <= st_e;
            e_exp_reg  <= qr[sega_pkg::QuoW-1:0];
            e_gain_reg <= gain_e;
            e_x_reg    <= {1'b0, gain_e, 5'b00000} + {2'b00, gain_e, 4'b0000}
                          + {5'b00000, gain_e, 1'b0} + sega_pkg::ISO_BIAS;
            p_st_reg   <= e_st_reg;
            p_exp_reg  <= e_exp_reg;
            p_gain_reg <= e_gain_reg;
            p_prod_reg <= e_x_reg * sega_pkg::ISO_RECIP;
            o_st_reg   <= p_st_reg;
            if (p_st_reg == sega_pkg::ST_OK)
            begin
                o_exp_reg  <= p_exp_reg;
                o_gain_reg <= p_gain_reg;
                o_iso_reg  <= p_prod_reg[sega_pkg::IsoShift+sega_pkg::IsoW-1:sega_pkg::IsoShift];
            end
            else
            begin
                o_exp_reg  <= '0;
                o_gain_reg <= '0;
                o_iso_reg  <= '0;
            end
        end
    end

    assign out_valid   = o_v_reg;
    assign status      = o_st_reg;
    assign exp_time_us = o_exp_reg;
    assign gain_milli  = o_gain_reg;
    assign iso_value   = o_iso_reg;

endmodule
`default_nettype wire

@@ hdl/sega_checker.sv @@
// Port-level checks for the exposure and gain metadata converter, bound to the top level.
`default_nettype none
module sega_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          m_axis_tvalid,
    input wire logic          m_axis_tready,
    input wire logic [71:0]   m_axis_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("Output beat changed while stalled.");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] != sega_pkg::ST_OK |->
        m_axis_tdata[71:2] == '0)
        else $error("Failed result carries non-zero values.");

    a_ok_exposure: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] == sega_pkg::ST_OK |->
        m_axis_tdata[33:2] != '0)
        else $error("Accepted result has zero exposure.");

    a_ok_gain: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] == sega_pkg::ST_OK |->
        m_axis_tdata[53:34] != '0 && m_axis_tdata[69:54] <= 16'd51188)
        else $error("Gain or ISO out of range.");

endmodule

bind sensor_exposure_gain_to_metadata_core sega_checker u_sega_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

@@ bench/testbench.sv @@
// Self-checking testbench for the exposure and gain to frame metadata converter.
`default_nettype none
module testbench;

    typedef struct packed {
        logic [15:0]       iso_value;
        logic [19:0]       gain_milli;
        logic [31:0]       exp_time_us;
        sega_pkg::status_t status;
    } meta_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [31:0] cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;

    logic [31:0] width_reg = sega_pkg::RST_ACTIVE_WIDTH;
    logic [31:0] blank_reg = sega_pkg::RST_HBLANK;
    logic [31:0] rate_reg  = sega_pkg::RST_PIXEL_RATE;

    meta_t expected_meta[$];
    int    send_idle_pct = 0;
    int    recv_idle_pct = 0;
    int    failures = 0;
    int    quiet_cycles = 0;

    localparam int QuietLimit = 20000;

    sensor_exposure_gain_to_metadata_core dut (.*);

    always #5 clk = ~clk;

    function automatic meta_t predict_metadata(logic [19:0] lines, logic [15:0] code);
        meta_t       m;
        logic [63:0] line_len, den, a, q1, r1, t, q2, r2, q;
        logic [31:0] gain, d;
        logic        exp_ok, gain_ok;
        m = '0;
        gain = 0;
        gain_ok = 1'b0;
        exp_ok = 1'b0;
        q = '0;
        line_len = 64'(width_reg) + 64'(blank_reg);
        if (width_reg == 0 || rate_reg == 0 || line_len > 64'hFFFF_FFFF) begin
            m.status = sega_pkg::ST_SETTING;
            return m;
        end
        if (lines != 0) begin
            den = 64'(rate_reg) * 16;
            a = 64'(lines) * line_len;
            q1 = a / den;
            r1 = a % den;
            if (q1 <= 64'd4295) begin
                t = r1 * 1000000;
                q2 = t / den;
                r2 = t % den;
                q = q1 * 1000000 + q2;
                if (!(q > 64'hFFFF_FFFF || (q == 64'hFFFF_FFFF && r2 != 0))) begin
                    if (2 * r2 >= den)
                        q++;
                    exp_ok = (q != 0 && q <= 64'hFFFF_FFFF);
                end
            end
        end
        if (!exp_ok) begin
            m.status = sega_pkg::ST_EXPOSURE;
            return m;
        end
        if (code >= 112 && code <= 1008) begin
            d = 1024 - code;
            gain = (2 * 1024000 + d) / (2 * d);
            gain_ok = 1'b1;
        end else if (code >= 1264 && code <= 5103) begin
            gain = 250 * (code - 1008);
            gain_ok = 1'b1;
        end
        if (!gain_ok) begin
            m.status = sega_pkg::ST_GAIN;
            return m;
        end
        m.status = sega_pkg::ST_OK;
        m.exp_time_us = q[31:0];
        m.gain_milli = gain[19:0];
        m.iso_value = 16'((64'(gain) * 50 + 500) / 1000);
        return m;
    endfunction

    always @(posedge clk) begin
        if (rst_n)
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk) begin
        meta_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            got = meta_t'(m_axis_tdata[69:0]);
            if (expected_meta.size() == 0) begin
                $error("unexpected result %h", m_axis_tdata);
                failures++;
            end else begin
                want = expected_meta.pop_front();
                if (got.status !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, got.status);
                    failures++;
                end
                if (got.exp_time_us !== want.exp_time_us) begin
                    $error("exp_time_us expected %0d actual %0d",
                           want.exp_time_us, got.exp_time_us);
                    failures++;
                end
                if (got.gain_milli !== want.gain_milli) begin
                    $error("gain_milli expected %0d actual %0d",
                           want.gain_milli, got.gain_milli);
                    failures++;
                end
                if (got.iso_value !== want.iso_value) begin
                    $error("iso_value expected %0d actual %0d",
                           want.iso_value, got.iso_value);
                    failures++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QuietLimit) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_exposure(logic [19:0] lines, logic [15:0] code);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'b0, code, lines};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        expected_meta.push_back(predict_metadata(lines, code));
    endtask

    task automatic drain_pipeline();
        s_axis_tvalid <= 1'b0;
        while (expected_meta.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_setting(sega_pkg::reg_idx_t idx, logic [31:0] value);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        case (idx)
            sega_pkg::REG_ACTIVE_WIDTH: width_reg = value;
            sega_pkg::REG_HBLANK:       blank_reg = value;
            sega_pkg::REG_PIXEL_RATE:   rate_reg = value;
            default:                    ;
        endcase
    endtask

    task automatic apply_mode(logic [31:0] w, logic [31:0] b, logic [31:0] r);
        drain_pipeline();
        write_setting(sega_pkg::REG_ACTIVE_WIDTH, w);
        write_setting(sega_pkg::REG_HBLANK, b);
        write_setting(sega_pkg::REG_PIXEL_RATE, r);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] random_gain_code();
        int pick;
        pick = $urandom_range(9);
        if (pick < 4)
            return 16'($urandom_range(1008, 112));
        if (pick < 8)
            return 16'($urandom_range(5103, 1264));
        return 16'($urandom);
    endfunction

    function automatic logic [19:0] random_lines();
        int pick;
        pick = $urandom_range(9);
        if (pick < 6)
            return 20'($urandom_range(20000, 1));
        if (pick < 9)
            return 20'($urandom);
        return 20'($urandom_range(3));
    endfunction

    task automatic test_directed_edges();
        send_exposure(20'd0, 16'd512);
        send_exposure(20'd1, 16'd512);
        send_exposure(20'hFFFFF, 16'd512);
        send_exposure(20'd16, 16'd111);
        send_exposure(20'd16, 16'd112);
        send_exposure(20'd16, 16'd1008);
        send_exposure(20'd16, 16'd1009);
        send_exposure(20'd16, 16'd1263);
        send_exposure(20'd16, 16'd1264);
        send_exposure(20'd16, 16'd5103);
        send_exposure(20'd16, 16'd5104);
        send_exposure(20'd16, 16'hFFFF);
        send_exposure(20'd16, 16'd0);
        send_exposure(20'hAAAAA, 16'h5555);
        send_exposure(20'h55555, 16'hAAAA);
    endtask

    task automatic test_setting_extremes();
        apply_mode(32'd0, 32'd100, 32'd1000000);
        send_exposure(20'd16, 16'd512);
        apply_mode(32'd100, 32'd100, 32'd0);
        send_exposure(20'd16, 16'd512);
        apply_mode(32'hFFFF_FFFF, 32'd1, 32'd1000000);
        send_exposure(20'd16, 16'd512);
        apply_mode(32'hFFFF_FFFE, 32'd1, 32'd1);
        send_exposure(20'd1, 16'd512);
        send_exposure(20'hFFFFF, 16'd2000);
        apply_mode(32'd1, 32'd0, 32'hFFFF_FFFF);
        send_exposure(20'd1, 16'd512);
        send_exposure(20'hFFFFF, 16'd512);
        apply_mode(32'd1, 32'd0, 32'd1000000);
        send_exposure(20'd8, 16'd512);
        send_exposure(20'd7, 16'd512);
        apply_mode(32'd3000, 32'd1000, 32'd1);
        send_exposure(20'd1, 16'd300);
        send_exposure(20'd1000, 16'd300);
    endtask

    task automatic test_random_traffic(int count);
        for (int i = 0; i < count; i++) begin
            if (i % 60 == 0) begin
                case ($urandom_range(3))
                    0: apply_mode(sega_pkg::RST_ACTIVE_WIDTH, sega_pkg::RST_HBLANK,
                                  sega_pkg::RST_PIXEL_RATE);
                    1: apply_mode($urandom_range(8000, 1), $urandom_range(8000),
                                  $urandom_range(900000000, 1000000));
                    2: apply_mode($urandom, $urandom, $urandom);
                    default: apply_mode($urandom_range(100, 1), $urandom_range(100),
                                        $urandom_range(100000, 1));
                endcase
            end
            send_exposure(random_lines(), random_gain_code());
        end
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle_pct = 21;
        recv_idle_pct = 59;
        test_directed_edges();
        test_setting_extremes();
        test_random_traffic(200);
        drain_pipeline();
        send_idle_pct = 59;
        recv_idle_pct = 21;
        test_random_traffic(200);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(220);
        drain_pipeline();
        if (failures == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
`default_nettype wire
